/* hw/rtl/imh_pkg.sv */
`timescale 1ns / 1ps

package imh_pkg;

    // fixed field widths
    localparam int VERTEX_W     = 6;
    localparam int VERTEX_COUNT = 64;
    localparam int IN_KEY_W     = 32;
    localparam int REMAIN_W     = 7;

    // parameter defaults
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_KEY_WIDTH   = 32;

    // operation codes
    localparam logic [2:0] MODE_APPEND   = 3'd0;
    localparam logic [2:0] MODE_BUILD    = 3'd1;
    localparam logic [2:0] MODE_EXTRACT  = 3'd2;
    localparam logic [2:0] MODE_DECREASE = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_LOWER = 2'd2;
    localparam logic [1:0] ST_FULL_DUP  = 2'd3;

    // sequencer states
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_APPEND   = 14'b00000000000010,
        S_BUILD_RD = 14'b00000000000100,
        S_BUILD_LD = 14'b00000000001000,
        S_DN_RD    = 14'b00000000010000,
        S_DN_CMP   = 14'b00000000100000,
        S_EX_RD    = 14'b00000001000000,
        S_EX_LD    = 14'b00000010000000,
        S_DEC_RD   = 14'b00000100000000,
        S_DEC_P    = 14'b00001000000000,
        S_DEC_CHK  = 14'b00010000000000,
        S_UP_RD    = 14'b00100000000000,
        S_UP_CMP   = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

endpackage

/* hw/rtl/indexed_min_heap_decrease_key_unit.sv */
`timescale 1ns / 1ps
// append and clear complete without any sift; extract moves the last entry to the root and
// sifts it down level by level (no sift when it removes the last entry); decrease either
// rejects or sifts the vertex up level by level toward the root; build sifts down each
// internal position in turn, from the last one to the root; one word in flight at a time
// the sift loops are paced by the heap memory
// reset: synchronous active-low aresetn empties the queue and clears all position valid bits
module indexed_min_heap_decrease_key_unit #(
    parameter int MAX_ENTRIES = imh_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_WIDTH   = imh_pkg::DEF_KEY_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_mode,
    input  logic [imh_pkg::VERTEX_W-1:0]  s_item_vertex,
    input  logic [imh_pkg::IN_KEY_W-1:0]  s_item_key,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [imh_pkg::VERTEX_W-1:0]  m_out_vertex,
    output logic [imh_pkg::IN_KEY_W-1:0]  m_out_key,
    output logic [1:0]                    m_status,
    output logic [imh_pkg::REMAIN_W-1:0]  m_remaining
);
    import imh_pkg::*;

    localparam int PW    = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = PW + 1;
    localparam int DEPTH = MAX_ENTRIES + 1;

    // heap memory, positions 1..count
    logic [VERTEX_W-1:0]  heap_v [DEPTH];
    logic [KEY_WIDTH-1:0] heap_k [DEPTH];
    // vertex position memory, valid bits mark queued vertices
    logic [PW-1:0]        vpos_mem [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] queued_reg;

    state_t state_reg, state_next;
    logic [PW-1:0] cnt_reg, pos_reg, bp_reg;
    logic build_reg;
    logic [VERTEX_W-1:0] vx_reg, cur_v_reg, rv_reg;
    logic [KEY_WIDTH-1:0] key_reg, cur_k_reg, rk_reg;
    logic [1:0] st_reg;
    logic m_valid_reg;
    logic [VERTEX_W-1:0] out_v_reg;
    logic [IN_KEY_W-1:0] out_k_reg;
    logic [1:0] out_st_reg;
    logic [REMAIN_W-1:0] out_rem_reg;

    // memory ports
    logic [PW-1:0] rd_a_addr, rd_b_addr, heap_wa;
    logic heap_we, vpos_we;
    logic [VERTEX_W-1:0] heap_wv, vpos_wa;
    logic [KEY_WIDTH-1:0] heap_wk;
    logic [PW-1:0] vpos_wd;
    logic [VERTEX_W-1:0] rd_a_v, rd_b_v;
    logic [KEY_WIDTH-1:0] rd_a_k, rd_b_k;
    logic [PW-1:0] vpos_rd;

    logic [CW-1:0] c1, c2, cnt_ext;
    logic c1_in, c2_in, l_ok, r_ok;
    logic [KEY_WIDTH-1:0] best_k;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_vertex = out_v_reg;
    assign m_out_key    = out_k_reg;
    assign m_status     = out_st_reg;
    assign m_remaining  = out_rem_reg;

    // child positions and sift-down compare
    always_comb begin
        cnt_ext = {1'b0, cnt_reg};
        c1      = {pos_reg, 1'b0};
        c2      = {pos_reg, 1'b1};
        c1_in   = (c1 <= cnt_ext);
        c2_in   = (c2 <= cnt_ext);
        l_ok    = c1_in && (rd_a_k < cur_k_reg);
        best_k  = l_ok ? rd_a_k : cur_k_reg;
        r_ok    = c2_in && (rd_b_k < best_k);
    end

    // read addresses and write strobes
    always_comb begin
        rd_a_addr = '0;
        rd_b_addr = '0;
        heap_we   = 1'b0;
        heap_wa   = pos_reg;
        heap_wv   = cur_v_reg;
        heap_wk   = cur_k_reg;
        vpos_we   = 1'b0;
        vpos_wa   = cur_v_reg;
        vpos_wd   = pos_reg;
        unique case (state_reg)
            S_APPEND: begin
                if (!(cnt_reg >= PW'(MAX_ENTRIES) || queued_reg[vx_reg])) begin
                    heap_we = 1'b1;
                    heap_wa = cnt_reg + PW'(1);
                    heap_wv = vx_reg;
                    heap_wk = key_reg;
                    vpos_we = 1'b1;
                    vpos_wa = vx_reg;
                    vpos_wd = cnt_reg + PW'(1);
                end
            end
            S_BUILD_RD: rd_a_addr = bp_reg;
            S_DN_RD: begin
                rd_a_addr = c1_in ? PW'(c1) : '0;
                rd_b_addr = c2_in ? PW'(c2) : '0;
            end
            S_DN_CMP: begin
                heap_we = 1'b1;
                vpos_we = 1'b1;
                if (r_ok) begin
                    heap_wv = rd_b_v;
                    heap_wk = rd_b_k;
                    vpos_wa = rd_b_v;
                end else if (l_ok) begin
                    heap_wv = rd_a_v;
                    heap_wk = rd_a_k;
                    vpos_wa = rd_a_v;
                end
            end
            S_EX_RD: begin
                rd_a_addr = PW'(1);
                rd_b_addr = cnt_reg;
            end
            S_DEC_P: rd_a_addr = queued_reg[vx_reg] ? vpos_rd : '0;
            S_UP_RD: begin
                if (pos_reg == PW'(1)) begin
                    heap_we = 1'b1;
                    vpos_we = 1'b1;
                end else begin
                    rd_a_addr = pos_reg >> 1;
                end
            end
            S_UP_CMP: begin
                heap_we = 1'b1;
                vpos_we = 1'b1;
                if (rd_a_k > cur_k_reg) begin
                    heap_wv = rd_a_v;
                    heap_wk = rd_a_k;
                    vpos_wa = rd_a_v;
                end
            end
            default: ;
        endcase
    end

    // heap memory: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_v[heap_wa] <= heap_wv;
            heap_k[heap_wa] <= heap_wk;
        end
        rd_a_v <= heap_v[rd_a_addr];
        rd_a_k <= heap_k[rd_a_addr];
        rd_b_v <= heap_v[rd_b_addr];
        rd_b_k <= heap_k[rd_b_addr];
    end

    // position memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (vpos_we) begin
            vpos_mem[vpos_wa] <= vpos_wd;
        end
        vpos_rd <= vpos_mem[vx_reg];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    priority case (s_mode)
                        MODE_APPEND:   state_next = S_APPEND;
                        MODE_BUILD:    state_next = ((cnt_reg >> 1) == '0) ? S_DONE
                                                                            : S_BUILD_RD;
                        MODE_EXTRACT:  state_next = (cnt_reg == '0) ? S_DONE : S_EX_RD;
                        MODE_DECREASE: state_next = S_DEC_RD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_APPEND:   state_next = S_DONE;
            S_BUILD_RD: state_next = S_BUILD_LD;
            S_BUILD_LD: state_next = S_DN_RD;
            S_DN_RD:    state_next = S_DN_CMP;
            S_DN_CMP: begin
                if (r_ok || l_ok) begin
                    state_next = S_DN_RD;
                end else if (build_reg && bp_reg > PW'(1)) begin
                    state_next = S_BUILD_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_EX_RD:    state_next = S_EX_LD;
            S_EX_LD:    state_next = (cnt_reg > PW'(1)) ? S_DN_RD : S_DONE;
            S_DEC_RD:   state_next = S_DEC_P;
            S_DEC_P:    state_next = S_DEC_CHK;
            S_DEC_CHK: begin
                if (!queued_reg[vx_reg] || pos_reg > cnt_reg || key_reg >= rd_a_k) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:    state_next = (pos_reg == PW'(1)) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   state_next = (rd_a_k > cur_k_reg) ? S_UP_RD : S_DONE;
            S_DONE:     state_next = (!m_valid_reg || m_ready) ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            queued_reg  <= '0;
            m_valid_reg <= 1'b0;
            build_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result word valid
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        build_reg <= (s_mode == MODE_BUILD);
                        if (s_mode == MODE_CLEAR) begin
                            cnt_reg    <= '0;
                            queued_reg <= '0;
                        end
                    end
                end
                S_APPEND: begin
                    if (!(cnt_reg >= PW'(MAX_ENTRIES) || queued_reg[vx_reg])) begin
                        cnt_reg            <= cnt_reg + PW'(1);
                        queued_reg[vx_reg] <= 1'b1;
                    end
                end
                S_EX_LD: begin
                    queued_reg[rd_a_v] <= 1'b0;
                    cnt_reg            <= cnt_reg - PW'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                vx_reg  <= s_item_vertex;
                key_reg <= KEY_WIDTH'(s_item_key);
                rv_reg  <= '0;
                rk_reg  <= '0;
                st_reg  <= (s_mode == MODE_EXTRACT && cnt_reg == '0) ? ST_EMPTY : ST_OK;
                bp_reg  <= cnt_reg >> 1;
            end
            S_APPEND: begin
                if (cnt_reg >= PW'(MAX_ENTRIES) || queued_reg[vx_reg]) begin
                    st_reg <= ST_FULL_DUP;
                end
            end
            S_BUILD_LD: begin
                cur_v_reg <= rd_a_v;
                cur_k_reg <= rd_a_k;
                pos_reg   <= bp_reg;
            end
            S_DN_CMP: begin
                if (r_ok) begin
                    pos_reg <= PW'(c2);
                end else if (l_ok) begin
                    pos_reg <= PW'(c1);
                end else begin
                    bp_reg <= bp_reg - PW'(1);
                end
            end
            S_EX_LD: begin
                rv_reg    <= rd_a_v;
                rk_reg    <= rd_a_k;
                cur_v_reg <= rd_b_v;
                cur_k_reg <= rd_b_k;
                pos_reg   <= PW'(1);
            end
            S_DEC_P: pos_reg <= vpos_rd;
            S_DEC_CHK: begin
                cur_v_reg <= vx_reg;
                cur_k_reg <= key_reg;
                if (!queued_reg[vx_reg] || pos_reg > cnt_reg || key_reg >= rd_a_k) begin
                    st_reg <= ST_NOT_LOWER;
                end
            end
            S_UP_CMP: begin
                if (rd_a_k > cur_k_reg) begin
                    pos_reg <= pos_reg >> 1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_v_reg   <= rv_reg;
                    out_k_reg   <= IN_KEY_W'(rk_reg);
                    out_st_reg  <= st_reg;
                    out_rem_reg <= REMAIN_W'(cnt_reg);
                end
            end
            default: ;
        endcase
    end

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= PW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_CLEAR) |=> (cnt_reg == '0 && queued_reg == '0))
        else $error("clear left entries");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_remaining == '0 && m_out_key == '0))
        else $error("empty status with entries");

endmodule
